### hw/rtl/kuf_pkg.sv
`default_nettype none

package kuf_pkg;

    // field widths
    localparam int EP_W    = 10;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 16;

    // default graph size
    localparam int VERTICES_DEF = 1024;

    // saturation limits
    localparam logic [RANK_W-1:0]  RANK_MAX  = {RANK_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // events from the sequencer to the result stage
    typedef struct packed {
        logic clear;   // new graph: zero both counters
        logic done;    // edge classified, result to be loaded
        logic joined;  // edge joined two components
    } t_seq_evt;

endpackage

`default_nettype wire

### hw/rtl/kuf_mem.sv
`default_nettype none

module kuf_mem #(
    parameter int DEPTH = kuf_pkg::VERTICES_DEF,
    parameter int AW    = 10,
    parameter int DW    = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    // one entry per vertex: {rank, parent}
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/kuf_cnt.sv
`default_nettype none

module kuf_cnt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire kuf_pkg::t_seq_evt            i_evt,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_in_tree,
    output logic [kuf_pkg::COUNT_W-1:0]       o_class_number,
    output logic                              o_free
);

    logic                        r_valid;
    logic                        r_in_tree;
    logic [kuf_pkg::COUNT_W-1:0] r_class;
    logic [kuf_pkg::COUNT_W-1:0] r_tree_cnt;
    logic [kuf_pkg::COUNT_W-1:0] r_spare_cnt;
    logic [kuf_pkg::COUNT_W-1:0] n_tree_cnt;
    logic [kuf_pkg::COUNT_W-1:0] n_spare_cnt;

    // saturating increments
    assign n_tree_cnt  = (r_tree_cnt == kuf_pkg::COUNT_MAX) ? r_tree_cnt
                                                             : r_tree_cnt + 1'b1;
    assign n_spare_cnt = (r_spare_cnt == kuf_pkg::COUNT_MAX) ? r_spare_cnt
                                                              : r_spare_cnt + 1'b1;

    // class counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_evt.clear) begin
            r_tree_cnt  <= '0;
            r_spare_cnt <= '0;
        end else if (i_evt.done) begin
            if (i_evt.joined) begin
                r_tree_cnt <= n_tree_cnt;
            end else begin
                r_spare_cnt <= n_spare_cnt;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_evt.done) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_evt.done) begin
            r_in_tree <= i_evt.joined;
            r_class   <= i_evt.joined ? n_tree_cnt : n_spare_cnt;
        end
    end

    assign o_free         = !r_valid || i_out_ready;
    assign o_out_valid    = r_valid;
    assign o_in_tree      = r_in_tree;
    assign o_class_number = r_class;

endmodule

`default_nettype wire

### hw/rtl/kuf_seq.sv
`default_nettype none

module kuf_seq #(
    parameter int VERTICES = kuf_pkg::VERTICES_DEF,
    parameter int VW       = 10,
    parameter int DW       = 14
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_new_graph,
    input  wire logic [kuf_pkg::EP_W-1:0]   i_endpoint_a,
    input  wire logic [kuf_pkg::EP_W-1:0]   i_endpoint_b,
    input  wire logic                       i_out_free,
    output kuf_pkg::t_seq_evt               o_evt,
    output logic                            o_mem_we,
    output logic [VW-1:0]                   o_mem_waddr,
    output logic [DW-1:0]                   o_mem_wdata,
    output logic [VW-1:0]                   o_mem_raddr,
    input  wire logic [DW-1:0]              i_mem_rdata
);

    localparam logic [VW-1:0] LAST_IDX = VW'(VERTICES - 1);
    localparam logic [16:0]   VERT_LIM = 17'(VERTICES);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CLEAR    = 9'b000000010,
        S_WALK_REQ = 9'b000000100,
        S_WALK_CHK = 9'b000001000,
        S_COMP_REQ = 9'b000010000,
        S_COMP_CHK = 9'b000100000,
        S_JOIN     = 9'b001000000,
        S_BUMP     = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state                      r_state,  n_state;
    logic [VW-1:0]               r_a,      n_a;
    logic [VW-1:0]               r_b,      n_b;
    logic                        r_inrange, n_inrange;
    logic                        r_side,   n_side;
    logic [VW-1:0]               r_cur,    n_cur;
    logic [VW-1:0]               r_ra,     n_ra;
    logic [VW-1:0]               r_rb,     n_rb;
    logic [kuf_pkg::RANK_W-1:0]  r_rank_a, n_rank_a;
    logic [kuf_pkg::RANK_W-1:0]  r_rank_b, n_rank_b;
    logic                        r_joined, n_joined;
    logic [VW-1:0]               r_clr,    n_clr;
    logic                        r_pend,   n_pend;

    logic [16:0]                 w_a_ext;
    logic [16:0]                 w_b_ext;
    logic                        w_in_rng;
    logic [VW-1:0]               w_top;
    logic [VW-1:0]               w_rd_par;
    logic [kuf_pkg::RANK_W-1:0]  w_rd_rank;

    // endpoint range check and index
    assign w_a_ext   = 17'(i_endpoint_a);
    assign w_b_ext   = 17'(i_endpoint_b);
    assign w_in_rng  = (w_a_ext < VERT_LIM) && (w_b_ext < VERT_LIM);

    // root of the side being compressed, fields of the read entry
    assign w_top     = r_side ? r_rb : r_ra;
    assign w_rd_par  = i_mem_rdata[VW-1:0];
    assign w_rd_rank = i_mem_rdata[DW-1:VW];

    assign o_in_ready = (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_inrange   = r_inrange;
        n_side      = r_side;
        n_cur       = r_cur;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_rank_a    = r_rank_a;
        n_rank_b    = r_rank_b;
        n_joined    = r_joined;
        n_clr       = r_clr;
        n_pend      = r_pend;
        o_evt       = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cur;
        o_mem_wdata = {w_rd_rank, w_top};
        o_mem_raddr = r_cur;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a       = w_a_ext[VW-1:0];
                    n_b       = w_b_ext[VW-1:0];
                    n_cur     = w_a_ext[VW-1:0];
                    n_inrange = w_in_rng;
                    n_side    = 1'b0;
                    n_joined  = 1'b0;
                    if (i_new_graph) begin
                        o_evt.clear = 1'b1;
                        n_clr       = '0;
                        n_pend      = 1'b1;
                        n_state     = S_CLEAR;
                    end else begin
                        n_state = w_in_rng ? S_WALK_REQ : S_DONE;
                    end
                end
            end
            // one entry a cycle back to a lone root of rank zero
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                o_mem_wdata = {{kuf_pkg::RANK_W{1'b0}}, r_clr};
                n_clr       = r_clr + 1'b1;
                if (r_clr == LAST_IDX) begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = r_inrange ? S_WALK_REQ : S_DONE;
                    end
                end
            end
            S_WALK_REQ: begin
                n_state = S_WALK_CHK;
            end
            // follow parent links up to the root
            S_WALK_CHK: begin
                if (w_rd_par == r_cur) begin
                    if (!r_side) begin
                        n_ra     = r_cur;
                        n_rank_a = w_rd_rank;
                        n_cur    = r_a;
                    end else begin
                        n_rb     = r_cur;
                        n_rank_b = w_rd_rank;
                        n_cur    = r_b;
                    end
                    n_state = S_COMP_REQ;
                end else begin
                    n_cur   = w_rd_par;
                    n_state = S_WALK_REQ;
                end
            end
            // second pass: point every vertex on the path at the root
            S_COMP_REQ: begin
                if (r_cur == w_top) begin
                    if (!r_side) begin
                        n_side  = 1'b1;
                        n_cur   = r_b;
                        n_state = S_WALK_REQ;
                    end else begin
                        n_state = S_JOIN;
                    end
                end else begin
                    n_state = S_COMP_CHK;
                end
            end
            S_COMP_CHK: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_cur;
                o_mem_wdata = {w_rd_rank, w_top};
                n_cur       = w_rd_par;
                n_state     = S_COMP_REQ;
            end
            // union by rank, endpoint a's root wins ties
            S_JOIN: begin
                if (r_ra == r_rb) begin
                    n_joined = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    n_joined = 1'b1;
                    o_mem_we = 1'b1;
                    if (r_rank_a < r_rank_b) begin
                        o_mem_waddr = r_ra;
                        o_mem_wdata = {r_rank_a, r_rb};
                        n_state     = S_DONE;
                    end else begin
                        o_mem_waddr = r_rb;
                        o_mem_wdata = {r_rank_b, r_ra};
                        if ((r_rank_a == r_rank_b) && (r_rank_a != kuf_pkg::RANK_MAX)) begin
                            n_state = S_BUMP;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_BUMP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ra;
                o_mem_wdata = {r_rank_a + 1'b1, r_ra};
                n_state     = S_DONE;
            end
            // hand the result over once the output register is free
            S_DONE: begin
                if (i_out_free) begin
                    o_evt.done   = 1'b1;
                    o_evt.joined = r_joined;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_inrange <= n_inrange;
        r_side    <= n_side;
        r_cur     <= n_cur;
        r_ra      <= n_ra;
        r_rb      <= n_rb;
        r_rank_a  <= n_rank_a;
        r_rank_b  <= n_rank_b;
        r_joined  <= n_joined;
    end

`ifndef ASSERT_OFF
    // the clearing sweep steps one entry a cycle without stopping
    a_clear_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr != LAST_IDX)
        |=> (r_state == S_CLEAR && r_clr == $past(r_clr) + 1'b1))
        else $error("clearing sweep broke off early");

    // finished compressing a's path, b's walk starts from endpoint b
    a_side_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP_REQ && r_cur == w_top && !r_side)
        |=> (r_state == S_WALK_REQ && r_side && r_cur == r_b))
        else $error("second endpoint walk not started");

    // a tree edge always joins two distinct roots
    a_join_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.done && o_evt.joined) |-> (r_ra != r_rb && r_inrange))
        else $error("tree edge reported with equal roots");

    // a result is only handed over when the output register can take it
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.done |-> i_out_free)
        else $error("result overwrote a waiting transaction");
`endif

endmodule

`default_nettype wire

### hw/rtl/kruskal_union_find_edge_classifier.sv
`default_nettype none

// channel   direction  handshake                    payload
// edge in   input      i_in_valid / o_in_ready      i_new_graph, i_endpoint_a, i_endpoint_b
// result    output     o_out_valid / i_out_ready    o_in_tree, o_class_number
//
// an edge walks from each endpoint to its root and then compresses that path
// (each hop is read, then read and rewritten during compression); a rank rise adds a write
// an edge with an endpoint out of range skips the walks and the join
// a new-graph transaction first sweeps the memory; after reset the
// same sweep runs with o_in_ready low
// a result waits in the output register; a later result stalls the sequencer until it is taken

module kruskal_union_find_edge_classifier #(
    parameter int VERTICES = kuf_pkg::VERTICES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_new_graph,
    input  wire logic [kuf_pkg::EP_W-1:0]      i_endpoint_a,
    input  wire logic [kuf_pkg::EP_W-1:0]      i_endpoint_b,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_in_tree,
    output logic [kuf_pkg::COUNT_W-1:0]        o_class_number
);

    localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int DW = kuf_pkg::RANK_W + VW;

    kuf_pkg::t_seq_evt w_evt;
    logic              w_out_free;
    logic              w_mem_we;
    logic [VW-1:0]     w_mem_waddr;
    logic [DW-1:0]     w_mem_wdata;
    logic [VW-1:0]     w_mem_raddr;
    logic [DW-1:0]     w_mem_rdata;

    // union-find sequencer
    kuf_seq #(
        .VERTICES (VERTICES),
        .VW       (VW),
        .DW       (DW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_new_graph  (i_new_graph),
        .i_endpoint_a (i_endpoint_a),
        .i_endpoint_b (i_endpoint_b),
        .i_out_free   (w_out_free),
        .o_evt        (w_evt),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    // parent and rank store
    kuf_mem #(
        .DEPTH (VERTICES),
        .AW    (VW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // class counters and output register
    kuf_cnt u_cnt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt          (w_evt),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_in_tree      (o_in_tree),
        .o_class_number (o_class_number),
        .o_free         (w_out_free)
    );

endmodule

`default_nettype wire
